@@ rtl/rau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared definitions for the rational arithmetic unit
// Opcodes, status codes, defaults and the handshake between sequencer and
// the shared shift/subtract unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;

  // opcodes
  localparam logic [2:0] OP_MUL   = 3'd0;
  localparam logic [2:0] OP_DIV   = 3'd1;
  localparam logic [2:0] OP_ADD   = 3'd2;
  localparam logic [2:0] OP_SUB   = 3'd3;
  localparam logic [2:0] OP_NORM  = 3'd4;
  localparam logic [2:0] OP_SCALE = 3'd5;
  localparam logic [2:0] OP_GCD   = 3'd6;
  localparam logic [2:0] OP_LCM   = 3'd7;

  // status codes
  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_ERR = 2'd1;
  localparam logic [1:0] STAT_OVF = 2'd2;

  // shared unit modes
  localparam logic UM_DIV = 1'b0;
  localparam logic UM_GCD = 1'b1;

  typedef struct packed {
    logic start;
    logic mode;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_rsp_t;

endpackage

@@ rtl/rau_iter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_iter_unit: shared shift/subtract engine
// Restoring division (one quotient bit per cycle) or binary GCD (one
// shift or subtract per cycle) on DW-bit unsigned operands.
// ----------------------------------------------------------------------------
module rau_iter_unit #(
  parameter int DW = 2 * rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rau_pkg::unit_req_t req,
  input  logic [DW-1:0]      x,
  input  logic [DW-1:0]      y,
  output rau_pkg::unit_rsp_t rsp,
  output logic [DW-1:0]      res
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          mode_r, mode_nxt;
  logic [DW-1:0] a_r, a_nxt;
  logic [DW-1:0] b_r, b_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem_r, a_r[DW-1]};
  assign diff  = trial - {1'b0, b_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mode_nxt = mode_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      mode_nxt = req.mode;
      a_nxt    = x;
      b_nxt    = y;
      rem_nxt  = '0;
      cnt_nxt  = (req.mode == rau_pkg::UM_DIV) ? CW'(DW) : '0;
    end else if (busy_r) begin
      if (mode_r == rau_pkg::UM_DIV) begin
        if (cnt_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
          if (!diff[DW]) begin
            rem_nxt = diff[DW-1:0];
            a_nxt   = {a_r[DW-2:0], 1'b1};
          end else begin
            rem_nxt = trial[DW-1:0];
            a_nxt   = {a_r[DW-2:0], 1'b0};
          end
        end
      end else begin
        if (b_r == '0) begin
          // one operand gone: restore the common power of two
          if (cnt_r == '0) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else begin
            a_nxt   = {a_r[DW-2:0], 1'b0};
            cnt_nxt = cnt_r - CW'(1);
          end
        end else if (a_r == '0) begin
          a_nxt = b_r;
          b_nxt = '0;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt   = a_r >> 1;
          b_nxt   = b_r >> 1;
          cnt_nxt = cnt_r + CW'(1);
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_r >= b_r) begin
          a_nxt = a_r - b_r;
        end else begin
          b_nxt = b_r - a_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mode_r <= mode_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign res      = a_r;

endmodule

@@ rtl/rational_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact arithmetic on signed fractions
// Multiply, divide, add, subtract, normalize, scale, gcd and lcm with
// binary-GCD reduction and a positive denominator.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Each beat is handled alone: in_stall is high
// from acceptance until the result has been loaded into the output register,
// and a new beat may be taken while that result still waits on out_stall.
// Divisions and GCDs run on the shared shift/subtract unit, one shift or
// subtract per step; a normalize is one GCD and two divisions. Add/subtract
// runs a GCD, two divisions and three multiplies, then the reduction; gcd of
// two operands is one GCD, and each product uses the 32x32 multiplier.
// Inputs use only their low OPERAND_WIDTH bits as two's complement; any
// result that does not fit that width signed reports overflow (status 2)
// with zero fields, and a zero denominator, a zero divisor or lcm(0,0) reports status 1.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic [1:0]         out_status
);

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = 2 * W;

  // reduction tail shared by multiply, divide, add, subtract and normalize
  localparam logic [3:0] S_RED_G = 4'd8;
  localparam logic [3:0] S_RED_N = 4'd9;
  localparam logic [3:0] S_RED_D = 4'd10;
  localparam logic [3:0] S_RED_E = 4'd11;

  localparam logic [1:0] DST_T0 = 2'd0;
  localparam logic [1:0] DST_T1 = 2'd1;
  localparam logic [1:0] DST_T2 = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CTRL = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_UNIT = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  function automatic logic [DW-1:0] zx(input logic [W-1:0] v);
    return {{W{1'b0}}, v};
  endfunction

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    return v[W-1] ? ((~v) + W'(1)) : v;
  endfunction

  state_t        state_r, state_nxt;
  logic [3:0]    step_r, step_nxt;
  logic [3:0]    ret_r, ret_nxt;
  logic [1:0]    dst_r, dst_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [W-1:0]  an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic          ans_r, ans_nxt, ads_r, ads_nxt, bns_r, bns_nxt, bds_r, bds_nxt;
  logic [DW-1:0] t0_r, t0_nxt, t1_r, t1_nxt, t2_r, t2_nxt;
  logic          neg_r, neg_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [W-1:0]  mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   res_num_r, res_num_nxt;
  logic [30:0]   res_den_r, res_den_nxt;
  logic [1:0]    status_r, status_nxt;

  logic [DW-1:0] mul_p;
  logic [DW-1:0] wb_val;
  logic          wb_en;

  // per-step launch requests
  logic          l_mul, l_unit, l_mode;
  logic [W-1:0]  l_ma, l_mb;
  logic [DW-1:0] l_x, l_y;
  logic [1:0]    l_dst;
  logic [3:0]    l_ret;

  // add/sub combine
  logic          sa, sb;
  logic [DW-1:0] nm_sum;
  logic          nm_neg;

  // output formatting
  logic [DW-1:0] lim;
  logic          fit_ok;
  logic [1:0]    st_fin;
  logic signed [W:0] snum;

  rau_pkg::unit_req_t unit_req;
  rau_pkg::unit_rsp_t unit_rsp;
  logic [DW-1:0]      unit_res;

  rau_iter_unit #(.DW(DW)) u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (unit_req),
    .x     (l_x),
    .y     (l_y),
    .rsp   (unit_rsp),
    .res   (unit_res)
  );

  assign mul_p = mul_a_r * mul_b_r;

  always_comb begin
    sa = ans_r ^ ads_r;
    sb = bns_r ^ bds_r ^ (op_r == rau_pkg::OP_SUB);
    if (sa == sb) begin
      nm_sum = t1_r + t2_r;
      nm_neg = sa;
    end else if (t1_r >= t2_r) begin
      nm_sum = t1_r - t2_r;
      nm_neg = sa;
    end else begin
      nm_sum = t2_r - t1_r;
      nm_neg = sb;
    end
  end

  always_comb begin
    lim    = DW'(1) << (W - 1);
    fit_ok = (neg_r ? (t0_r <= lim) : (t0_r < lim)) && (t1_r < lim);
    st_fin = (st_r == rau_pkg::STAT_OK && !fit_ok) ? rau_pkg::STAT_OVF : st_r;
    snum   = neg_r ? -$signed({1'b0, t0_r[W-1:0]}) : $signed({1'b0, t0_r[W-1:0]});
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    ret_nxt       = ret_r;
    dst_nxt       = dst_r;
    op_nxt        = op_r;
    an_nxt = an_r;  ad_nxt = ad_r;  bn_nxt = bn_r;  bd_nxt = bd_r;
    ans_nxt = ans_r; ads_nxt = ads_r; bns_nxt = bns_r; bds_nxt = bds_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    neg_nxt       = neg_r;
    st_nxt        = st_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    res_num_nxt   = res_num_r;
    res_den_nxt   = res_den_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    l_mul  = 1'b0;
    l_unit = 1'b0;
    l_mode = rau_pkg::UM_DIV;
    l_ma   = '0;
    l_mb   = '0;
    l_x    = '0;
    l_y    = '0;
    l_dst  = DST_T0;
    l_ret  = '0;
    unit_req = '0;
    wb_en  = 1'b0;
    wb_val = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_op;
          an_nxt   = mag_of(in_a_num[W-1:0]);
          ad_nxt   = mag_of(in_a_den[W-1:0]);
          bn_nxt   = mag_of(in_b_num[W-1:0]);
          bd_nxt   = mag_of(in_b_den[W-1:0]);
          ans_nxt  = in_a_num[W-1];
          ads_nxt  = in_a_den[W-1];
          bns_nxt  = in_b_num[W-1];
          bds_nxt  = in_b_den[W-1];
          step_nxt = '0;
          st_nxt   = rau_pkg::STAT_OK;
          neg_nxt  = 1'b0;
          state_nxt = ST_CTRL;
        end
      end

      ST_CTRL: begin
        if (step_r >= S_RED_G) begin
          case (step_r)
            S_RED_G: begin
              l_unit = 1'b1; l_mode = rau_pkg::UM_GCD;
              l_x = t0_r; l_y = t1_r; l_dst = DST_T2; l_ret = S_RED_N;
            end
            S_RED_N: begin
              l_unit = 1'b1; l_x = t0_r; l_y = t2_r; l_dst = DST_T0; l_ret = S_RED_D;
            end
            S_RED_D: begin
              l_unit = 1'b1; l_x = t1_r; l_y = t2_r; l_dst = DST_T1; l_ret = S_RED_E;
            end
            default: begin
              if (t0_r == '0) neg_nxt = 1'b0;
              state_nxt = ST_EMIT;
            end
          endcase
        end else begin
          case (op_r)
            rau_pkg::OP_MUL, rau_pkg::OP_DIV: begin
              case (step_r)
                4'd0: begin
                  if (ad_r == '0 || bd_r == '0 ||
                      (op_r == rau_pkg::OP_DIV && bn_r == '0)) begin
                    st_nxt = rau_pkg::STAT_ERR;
                    state_nxt = ST_EMIT;
                  end else begin
                    neg_nxt = ans_r ^ ads_r ^ bns_r ^ bds_r;
                    l_mul = 1'b1; l_ma = an_r;
                    l_mb = (op_r == rau_pkg::OP_MUL) ? bn_r : bd_r;
                    l_dst = DST_T0; l_ret = 4'd1;
                  end
                end
                default: begin
                  l_mul = 1'b1; l_ma = ad_r;
                  l_mb = (op_r == rau_pkg::OP_MUL) ? bd_r : bn_r;
                  l_dst = DST_T1; l_ret = S_RED_G;
                end
              endcase
            end

            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
              case (step_r)
                4'd0: begin
                  if (ad_r == '0 || bd_r == '0) begin
                    st_nxt = rau_pkg::STAT_ERR;
                    state_nxt = ST_EMIT;
                  end else begin
                    l_unit = 1'b1; l_mode = rau_pkg::UM_GCD;
                    l_x = zx(ad_r); l_y = zx(bd_r); l_dst = DST_T2; l_ret = 4'd1;
                  end
                end
                4'd1: begin
                  l_unit = 1'b1; l_x = zx(ad_r); l_y = t2_r; l_dst = DST_T0; l_ret = 4'd2;
                end
                4'd2: begin
                  l_unit = 1'b1; l_x = zx(bd_r); l_y = t2_r; l_dst = DST_T1; l_ret = 4'd3;
                end
                4'd3: begin
                  l_mul = 1'b1; l_ma = an_r; l_mb = t1_r[W-1:0];
                  l_dst = DST_T1; l_ret = 4'd4;
                end
                4'd4: begin
                  l_mul = 1'b1; l_ma = bn_r; l_mb = t0_r[W-1:0];
                  l_dst = DST_T2; l_ret = 4'd5;
                end
                4'd5: begin
                  l_mul = 1'b1; l_ma = t0_r[W-1:0]; l_mb = bd_r;
                  l_dst = DST_T0; l_ret = 4'd6;
                end
                default: begin
                  t0_nxt   = nm_sum;
                  t1_nxt   = t0_r;
                  neg_nxt  = nm_neg;
                  step_nxt = S_RED_G;
                end
              endcase
            end

            rau_pkg::OP_NORM: begin
              if (ad_r == '0) begin
                st_nxt = rau_pkg::STAT_ERR;
                state_nxt = ST_EMIT;
              end else begin
                t0_nxt   = zx(an_r);
                t1_nxt   = zx(ad_r);
                neg_nxt  = ans_r ^ ads_r;
                step_nxt = S_RED_G;
              end
            end

            rau_pkg::OP_SCALE: begin
              case (step_r)
                4'd0: begin
                  if (ad_r == '0) begin
                    st_nxt = rau_pkg::STAT_ERR;
                    state_nxt = ST_EMIT;
                  end else begin
                    l_mul = 1'b1; l_ma = an_r; l_mb = bn_r; l_dst = DST_T0; l_ret = 4'd1;
                  end
                end
                4'd1: begin
                  l_unit = 1'b1; l_x = t0_r; l_y = zx(ad_r); l_dst = DST_T0; l_ret = 4'd2;
                end
                default: begin
                  neg_nxt   = (t0_r != '0) && (ans_r ^ bns_r ^ ads_r);
                  t1_nxt    = DW'(1);
                  state_nxt = ST_EMIT;
                end
              endcase
            end

            rau_pkg::OP_GCD: begin
              case (step_r)
                4'd0: begin
                  l_unit = 1'b1; l_mode = rau_pkg::UM_GCD;
                  l_x = zx(an_r); l_y = zx(bn_r); l_dst = DST_T0; l_ret = 4'd1;
                end
                default: begin
                  neg_nxt   = 1'b0;
                  t1_nxt    = DW'(1);
                  state_nxt = ST_EMIT;
                end
              endcase
            end

            default: begin // lcm
              case (step_r)
                4'd0: begin
                  l_unit = 1'b1; l_mode = rau_pkg::UM_GCD;
                  l_x = zx(an_r); l_y = zx(bn_r); l_dst = DST_T2; l_ret = 4'd1;
                end
                4'd1: begin
                  if (t2_r == '0) begin
                    st_nxt = rau_pkg::STAT_ERR;
                    state_nxt = ST_EMIT;
                  end else begin
                    l_unit = 1'b1; l_x = zx(an_r); l_y = t2_r; l_dst = DST_T0; l_ret = 4'd2;
                  end
                end
                4'd2: begin
                  l_mul = 1'b1; l_ma = t0_r[W-1:0]; l_mb = bn_r;
                  l_dst = DST_T0; l_ret = 4'd3;
                end
                default: begin
                  neg_nxt   = (t0_r != '0) && (ans_r ^ bns_r);
                  t1_nxt    = DW'(1);
                  state_nxt = ST_EMIT;
                end
              endcase
            end
          endcase
        end

        if (l_mul) begin
          mul_a_nxt = l_ma;
          mul_b_nxt = l_mb;
          dst_nxt   = l_dst;
          ret_nxt   = l_ret;
          state_nxt = ST_MUL;
        end else if (l_unit) begin
          unit_req.start = 1'b1;
          unit_req.mode  = l_mode;
          dst_nxt   = l_dst;
          ret_nxt   = l_ret;
          state_nxt = ST_UNIT;
        end
      end

      ST_MUL: begin
        wb_en     = 1'b1;
        wb_val    = mul_p;
        step_nxt  = ret_r;
        state_nxt = ST_CTRL;
      end

      ST_UNIT: begin
        if (unit_rsp.done) begin
          wb_en     = 1'b1;
          wb_val    = unit_res;
          step_nxt  = ret_r;
          state_nxt = ST_CTRL;
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          status_nxt    = st_fin;
          if (st_fin != rau_pkg::STAT_OK) begin
            res_num_nxt = '0;
            res_den_nxt = '0;
          end else begin
            res_num_nxt = 32'(snum);
            res_den_nxt = 31'(t1_r[W-2:0]);
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (wb_en) begin
      case (dst_r)
        DST_T0:  t0_nxt = wb_val;
        DST_T1:  t1_nxt = wb_val;
        default: t2_nxt = wb_val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r    <= step_nxt;
    ret_r     <= ret_nxt;
    dst_r     <= dst_nxt;
    op_r      <= op_nxt;
    an_r      <= an_nxt;
    ad_r      <= ad_nxt;
    bn_r      <= bn_nxt;
    bd_r      <= bd_nxt;
    ans_r     <= ans_nxt;
    ads_r     <= ads_nxt;
    bns_r     <= bns_nxt;
    bds_r     <= bds_nxt;
    t0_r      <= t0_nxt;
    t1_r      <= t1_nxt;
    t2_r      <= t2_nxt;
    neg_r     <= neg_nxt;
    st_r      <= st_nxt;
    mul_a_r   <= mul_a_nxt;
    mul_b_r   <= mul_b_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
    status_r  <= status_nxt;
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;
  assign out_status  = status_r;

`ifndef NO_ASSERTIONS
  // the shared unit only reports completion while the sequencer waits on it
  a_done_in_unit: assert property (@(posedge clk) disable iff (!rst_n)
    unit_rsp.done |-> state_r == ST_UNIT)
    else $error("shared unit finished outside its wait state");

  // a good result always carries a nonzero denominator
  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == rau_pkg::STAT_OK |-> res_den_r != '0)
    else $error("ok result with zero denominator");

  // a failed result carries zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != rau_pkg::STAT_OK |-> res_num_r == '0 && res_den_r == '0)
    else $error("error result with nonzero fields");

  // a launch never hits a unit that is still busy
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    unit_req.start |-> !unit_rsp.busy)
    else $error("shared unit started while busy");
`endif

endmodule

@@ dv/rational_arithmetic_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test: self-checking bench for the rational unit
// A queue of operand beats feeds a falling-edge driver. A rising-edge monitor
// predicts each accepted beat exactly and checks every result beat in order.
// Both sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test;

  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM   = 1200;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } operands_t;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  status;
  } fraction_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = rau_pkg::OP_MUL;
  logic signed [31:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [31:0] out_res_num;
  logic [30:0] out_res_den;
  logic [1:0]  out_status;

  operands_t pending_beats[$];
  fraction_t expected_fracs[$];
  int  n_mismatch = 0;
  int  n_accepted = 0;
  int  idle_cycles = 0;
  int  cycle_cnt = 0;
  bit  in_taken = 1'b0;   // input beat accepted at the last rising edge
  bit  timed_out = 1'b0;

  rational_arithmetic_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_status(out_status)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // ---------------------------------------------------------------- predictor
  // Two's complement magnitude; the most negative value gives 2^31.
  function automatic logic [63:0] magnitude(logic [31:0] v);
    return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
  endfunction

  function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic bit fits32(bit neg, logic [63:0] mag);
    return neg ? (mag <= 64'h8000_0000) : (mag < 64'h8000_0000);
  endfunction

  // Pack a sign/magnitude result; out-of-range values become overflow.
  function automatic fraction_t pack_result(bit neg, logic [63:0] mag,
                                            logic [63:0] den, logic [1:0] st);
    fraction_t r;
    logic [63:0] sv;
    if (st == rau_pkg::STAT_OK && (!fits32(neg, mag) || !fits32(1'b0, den)))
      st = rau_pkg::STAT_OVF;
    sv = neg ? (64'd0 - mag) : mag;
    r.num    = (st == rau_pkg::STAT_OK) ? sv[31:0] : 32'd0;
    r.den    = (st == rau_pkg::STAT_OK) ? den[30:0] : 31'd0;
    r.status = st;
    return r;
  endfunction

  function automatic fraction_t reduce_frac(bit neg, logic [63:0] nm, logic [63:0] dm);
    logic [63:0] g;
    g  = euclid(nm, dm);
    nm = nm / g;
    dm = dm / g;
    if (nm == 0) neg = 1'b0;
    return pack_result(neg, nm, dm, rau_pkg::STAT_OK);
  endfunction

  function automatic fraction_t predict_rational(operands_t b);
    logic [63:0] an, ad, bn, bd, g, ta, tb, den, nm, q;
    bit sa, sb, neg;
    fraction_t err;
    an = magnitude(b.a_num); ad = magnitude(b.a_den);
    bn = magnitude(b.b_num); bd = magnitude(b.b_den);
    err = pack_result(1'b0, 64'd0, 64'd0, rau_pkg::STAT_ERR);
    case (b.op)
      rau_pkg::OP_MUL: begin
        if (ad == 0 || bd == 0) return err;
        return reduce_frac(b.a_num[31] ^ b.a_den[31] ^ b.b_num[31] ^ b.b_den[31],
                           an * bn, ad * bd);
      end
      rau_pkg::OP_DIV: begin
        if (ad == 0 || bd == 0 || bn == 0) return err;
        return reduce_frac(b.a_num[31] ^ b.a_den[31] ^ b.b_num[31] ^ b.b_den[31],
                           an * bd, ad * bn);
      end
      rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
        if (ad == 0 || bd == 0) return err;
        // common denominator is the lcm of the two denominators
        g   = euclid(ad, bd);
        den = (ad / g) * bd;
        ta  = an * (bd / g);
        tb  = bn * (ad / g);
        sa  = b.a_num[31] ^ b.a_den[31];
        sb  = b.b_num[31] ^ b.b_den[31] ^ (b.op == rau_pkg::OP_SUB);
        if (sa == sb) begin
          nm = ta + tb; neg = sa;
        end else if (ta >= tb) begin
          nm = ta - tb; neg = sa;
        end else begin
          nm = tb - ta; neg = sb;
        end
        return reduce_frac(neg, nm, den);
      end
      rau_pkg::OP_NORM: begin
        if (ad == 0) return err;
        return reduce_frac(b.a_num[31] ^ b.a_den[31], an, ad);
      end
      rau_pkg::OP_SCALE: begin
        if (ad == 0) return err;
        q = (an * bn) / ad;
        return pack_result(q != 0 && (b.a_num[31] ^ b.b_num[31] ^ b.a_den[31]),
                           q, 64'd1, rau_pkg::STAT_OK);
      end
      rau_pkg::OP_GCD: return pack_result(1'b0, euclid(an, bn), 64'd1, rau_pkg::STAT_OK);
      default: begin
        g = euclid(an, bn);
        if (g == 0) return err;   // lcm of two zeros
        q = (an / g) * bn;
        return pack_result(q != 0 && (b.a_num[31] ^ b.b_num[31]), q, 64'd1,
                           rau_pkg::STAT_OK);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus
  // Mostly small values so many results stay in range; some full-width,
  // extremes and powers of two.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4: v = $urandom_range(100, 0) - 50;
      5, 6:          v = $urandom_range(200000, 0) - 100000;
      7:             v = $urandom;
      8: begin
        case ($urandom_range(4, 0))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'd0;
          3: v = 32'd1;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        v = 32'd1 << $urandom_range(31, 0);
        if ($urandom_range(1, 0)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic add_beat(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                          logic [31:0] bn, logic [31:0] bd);
    operands_t b;
    b.op = op; b.a_num = an; b.a_den = ad; b.b_num = bn; b.b_den = bd;
    pending_beats.push_back(b);
  endtask

  // Phase follows progress: none, sender idles, receiver stalls, both.
  // While bits 7:6 of the cycle counter are zero, nothing idles at all.
  function automatic int idle_pct(bit rx_side);
    int phase;
    phase = (n_accepted / 310) % 4;
    if (cycle_cnt[7:6] == 2'd0) return 0;
    case (phase)
      1: return rx_side ? 0 : 55;
      2: return rx_side ? 55 : 0;
      3: return 33;
      default: return 0;
    endcase
  endfunction

  // Driver: new beat only when the last one was taken or none was offered.
  always @(negedge clk) begin
    operands_t b;
    bit        next_valid;
    cycle_cnt <= cycle_cnt + 1;
    out_stall <= rst_n && ($urandom_range(99, 0) < idle_pct(1'b1));
    next_valid = in_valid;
    if (rst_n && (!in_valid || in_taken)) begin
      next_valid = 1'b0;
      if (pending_beats.size() != 0 && $urandom_range(99, 0) >= idle_pct(1'b0)) begin
        b = pending_beats.pop_front();
        in_op    <= b.op;
        in_a_num <= b.a_num; in_a_den <= b.a_den;
        in_b_num <= b.b_num; in_b_den <= b.b_den;
        next_valid = 1'b1;
      end
    end
    in_valid <= next_valid;
  end

  // Monitor: predict at input acceptance, check at output acceptance.
  always @(posedge clk) begin
    operands_t b;
    fraction_t exp_r;
    bit        moved;
    moved    = 1'b0;
    in_taken = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      b.op = in_op; b.a_num = in_a_num; b.a_den = in_a_den;
      b.b_num = in_b_num; b.b_den = in_b_den;
      expected_fracs.push_back(predict_rational(b));
      in_taken = 1'b1;
      moved    = 1'b1;
      n_accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      if (expected_fracs.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("ERROR: unexpected result beat num=%0d den=%0d status=%0d",
                   out_res_num, out_res_den, out_status);
      end else begin
        exp_r = expected_fracs.pop_front();
        if (out_res_num !== exp_r.num || out_res_den !== exp_r.den ||
            out_status !== exp_r.status) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("ERROR: result exp %0d/%0d st %0d, got %0d/%0d st %0d",
                     $signed(exp_r.num), exp_r.den, exp_r.status,
                     out_res_num, out_res_den, out_status);
        end
      end
    end
    // watchdog: cycles with no beat moving on either side
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) timed_out = 1'b1;
  end

  initial begin
    rst_n = 1'b0;

    // directed: every op, zero denominators, extremes, overflow
    add_beat(rau_pkg::OP_MUL,   3, 4, -2, 9);
    add_beat(rau_pkg::OP_MUL,   1, 0, 2, 3);                        // zero denominator
    add_beat(rau_pkg::OP_MUL,   32'h8000_0000, 1, 32'h8000_0000, 1); // overflow
    add_beat(rau_pkg::OP_DIV,   -6, 7, 3, -14);
    add_beat(rau_pkg::OP_DIV,   5, 3, 0, 2);                        // divide by zero fraction
    add_beat(rau_pkg::OP_ADD,   1, 6, 1, 10);
    add_beat(rau_pkg::OP_ADD,   32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
    add_beat(rau_pkg::OP_ADD,   1, 32'h8000_0000, -1, 32'h7FFF_FFFF);
    add_beat(rau_pkg::OP_SUB,   5, 8, 5, 8);                        // zero result
    add_beat(rau_pkg::OP_SUB,   -3, 4, 7, -6);
    add_beat(rau_pkg::OP_SUB,   1, 2, 1, 0);
    add_beat(rau_pkg::OP_NORM,  -12, -18, 0, 0);
    add_beat(rau_pkg::OP_NORM,  32'h8000_0000, -1, 0, 0);           // overflow on negate
    add_beat(rau_pkg::OP_NORM,  0, 32'h8000_0000, 0, 0);
    add_beat(rau_pkg::OP_NORM,  7, 0, 0, 0);
    add_beat(rau_pkg::OP_SCALE, 7, 2, -3, 0);                       // truncates toward zero
    add_beat(rau_pkg::OP_SCALE, 32'h7FFF_FFFF, 1, 2, 0);
    add_beat(rau_pkg::OP_SCALE, 1, 0, 1, 0);
    add_beat(rau_pkg::OP_GCD,   -48, 0, 18, 0);
    add_beat(rau_pkg::OP_GCD,   0, 0, 0, 0);
    add_beat(rau_pkg::OP_GCD,   32'h8000_0000, 0, 0, 0);            // gcd too large
    add_beat(rau_pkg::OP_LCM,   -4, 0, 6, 0);
    add_beat(rau_pkg::OP_LCM,   0, 0, 0, 0);                        // lcm undefined
    add_beat(rau_pkg::OP_LCM,   0, 0, 9, 0);
    add_beat(rau_pkg::OP_LCM,   32'h7FFF_FFFF, 0, 32'h7FFF_FFFE, 0);
    for (int i = 0; i < N_RANDOM; i++)
      add_beat(3'($urandom_range(7, 0)), pick_value(), pick_value(),
               pick_value(), pick_value());

    repeat (12) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (!timed_out && (pending_beats.size() != 0 || in_valid ||
                          expected_fracs.size() != 0))
      @(posedge clk);
    if (!timed_out) repeat (700) @(posedge clk);  // drain: no stray beats

    if (timed_out || n_mismatch != 0) begin
      $display("simulation failed");
    end else begin
      $display("simulation ok");
    end
    $finish;
  end

endmodule
